// File: design/radix_tree_node_builder_top_macros.svh
// assertion macros shared by the checker
`ifndef RADIX_TREE_NODE_BUILDER_TOP_MACROS_SVH
`define RADIX_TREE_NODE_BUILDER_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RTNB_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtnb checker: property failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define RTNB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtnb checker: property failed");

`endif

// File: design/rtnb_pkg.sv
`timescale 1ns / 1ps
package rtnb_pkg;

  // field and index widths
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned PLEN_W      = 6;
  localparam int unsigned LMAX_W      = 12;
  localparam int unsigned SIDX_W      = 13;
  localparam int unsigned MAX_OBJECTS = 1024;
  localparam int unsigned MIN_OBJECTS = 2;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MIN_OBJECTS);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_BUILD = 1'b1
  } rtnb_cmd_code_e;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] load_slot;
    logic [KEY_W-1:0] key_value;
    logic [IDX_W-1:0] node_index;
  } rtnb_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] range_first;
    logic [IDX_W-1:0] range_last;
    logic [IDX_W-1:0] split_point;
    logic             left_is_leaf;
    logic             right_is_leaf;
    logic             node_invalid;
  } rtnb_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD_UP,
    ST_RD_DOWN,
    ST_DIR,
    ST_EXP_ADDR,
    ST_EXP_CHK,
    ST_BIN_ADDR,
    ST_BIN_CHK,
    ST_SPL_LO,
    ST_SPL_HI,
    ST_SPL_CMP,
    ST_SPL_ADDR,
    ST_SPL_CHK,
    ST_DONE
  } rtnb_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_RD_SELF,
    OP_RD_UP,
    OP_RD_DOWN,
    OP_DIR,
    OP_EXP_RD,
    OP_EXP_GROW,
    OP_BIN_INIT,
    OP_BIN_RD,
    OP_BIN_SKIP,
    OP_BIN_CHK,
    OP_RANGE,
    OP_ROOT,
    OP_SPL_RD_LO,
    OP_SPL_RD_HI,
    OP_SPL_CMP,
    OP_SPL_ADDR,
    OP_SPL_CHK,
    OP_EMIT
  } rtnb_op_e;

  // controller to datapath
  typedef struct packed {
    rtnb_op_e op;
  } rtnb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic invalid;
    logic root;
    logic exp_in;
    logic gt;
    logic t_zero;
    logic bin_in;
    logic keys_equal;
    logic cand_ok;
    logic more_nx;
    logic more_q;
  } rtnb_stat_t;

  // leading-zero count of a 32-bit word, zero counts as 32
  function automatic logic [PLEN_W-1:0] lzc32(input logic [31:0] x);
    logic [31:0]       v;
    logic [PLEN_W-1:0] n;
    v = x;
    n = '0;
    if (x == 32'd0) begin
      n = PLEN_W'(32);
    end else begin
      if (v[31:16] == 16'd0) begin
        n[4] = 1'b1;
        v = v << 16;
      end
      if (v[31:24] == 8'd0) begin
        n[3] = 1'b1;
        v = v << 8;
      end
      if (v[31:28] == 4'd0) begin
        n[2] = 1'b1;
        v = v << 4;
      end
      if (v[31:30] == 2'd0) begin
        n[1] = 1'b1;
        v = v << 2;
      end
      if (!v[31]) begin
        n[0] = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: design/rtnb_ram.sv
`timescale 1ns / 1ps
module rtnb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rtnb_ctrl.sv
`timescale 1ns / 1ps
module rtnb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_command_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  rtnb_pkg::rtnb_stat_t stat_i,
  output rtnb_pkg::rtnb_cmd_t  cmd_o
);
  import rtnb_pkg::*;

  rtnb_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_command_i == CMD_LOAD) begin
            cmd_o.op = OP_LOAD;
          end else begin
            cmd_o.op = OP_START;
            state_d  = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat_i.invalid) begin
          state_d = ST_DONE;
        end else if (stat_i.root) begin
          cmd_o.op = OP_ROOT;
          state_d  = ST_SPL_LO;
        end else begin
          cmd_o.op = OP_RD_SELF;
          state_d  = ST_RD_UP;
        end
      end
      ST_RD_UP: begin
        cmd_o.op = OP_RD_UP;
        state_d  = ST_RD_DOWN;
      end
      ST_RD_DOWN: begin
        cmd_o.op = OP_RD_DOWN;
        state_d  = ST_DIR;
      end
      ST_DIR: begin
        cmd_o.op = OP_DIR;
        state_d  = ST_EXP_ADDR;
      end
      // exponential search for the far bound
      ST_EXP_ADDR: begin
        if (stat_i.exp_in) begin
          cmd_o.op = OP_EXP_RD;
          state_d  = ST_EXP_CHK;
        end else begin
          cmd_o.op = OP_BIN_INIT;
          state_d  = ST_BIN_ADDR;
        end
      end
      ST_EXP_CHK: begin
        if (stat_i.gt) begin
          cmd_o.op = OP_EXP_GROW;
          state_d  = ST_EXP_ADDR;
        end else begin
          cmd_o.op = OP_BIN_INIT;
          state_d  = ST_BIN_ADDR;
        end
      end
      // binary search for the range end
      ST_BIN_ADDR: begin
        if (stat_i.t_zero) begin
          cmd_o.op = OP_RANGE;
          state_d  = ST_SPL_LO;
        end else if (stat_i.bin_in) begin
          cmd_o.op = OP_BIN_RD;
          state_d  = ST_BIN_CHK;
        end else begin
          cmd_o.op = OP_BIN_SKIP;
        end
      end
      ST_BIN_CHK: begin
        cmd_o.op = OP_BIN_CHK;
        state_d  = ST_BIN_ADDR;
      end
      // split search
      ST_SPL_LO: begin
        cmd_o.op = OP_SPL_RD_LO;
        state_d  = ST_SPL_HI;
      end
      ST_SPL_HI: begin
        cmd_o.op = OP_SPL_RD_HI;
        state_d  = ST_SPL_CMP;
      end
      ST_SPL_CMP: begin
        cmd_o.op = OP_SPL_CMP;
        state_d  = stat_i.keys_equal ? ST_DONE : ST_SPL_ADDR;
      end
      ST_SPL_ADDR: begin
        cmd_o.op = OP_SPL_ADDR;
        if (stat_i.cand_ok) begin
          state_d = ST_SPL_CHK;
        end else if (!stat_i.more_nx) begin
          state_d = ST_DONE;
        end
      end
      ST_SPL_CHK: begin
        cmd_o.op = OP_SPL_CHK;
        state_d  = stat_i.more_q ? ST_SPL_ADDR : ST_DONE;
      end
      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/rtnb_dp.sv
`timescale 1ns / 1ps
module rtnb_dp #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rtnb_pkg::rtnb_cmd_t               cmd_i,
  output rtnb_pkg::rtnb_stat_t              stat_o,
  input  rtnb_pkg::rtnb_in_t                in_data_i,
  input  logic                              cfg_valid_i,
  input  logic [rtnb_pkg::CNT_W-1:0]        cfg_data_i,
  output logic                              ram_we_o,
  output logic [rtnb_pkg::IDX_W-1:0]        ram_waddr_o,
  output logic [KEY_BITS-1:0]               ram_wdata_o,
  output logic                              ram_re_o,
  output logic [rtnb_pkg::IDX_W-1:0]        ram_raddr_o,
  input  logic [KEY_BITS-1:0]               ram_rdata_i,
  output rtnb_pkg::rtnb_out_t               res_o
);
  import rtnb_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  idx_q, last_q, lo_q, hi_q, split_q, cand_q;
  logic              invalid_q, neg_q;
  logic [KEY_BITS-1:0] code_q;
  logic [PLEN_W-1:0] up_q, thr_q;
  logic [LMAX_W-1:0] lmax_q, l_q, t_q;
  logic [CNT_W-1:0]  step_q;
  rtnb_out_t         res_q;

  logic [CNT_W-1:0]  n_clamp, last_n, step_nx, cand_sum, lohi_sum;
  logic [CNT_W:0]    step_inc;
  logic              node_bad;
  logic [31:0]       rd_ext, code_ext;
  logic [PLEN_W-1:0] plen_rd;
  logic signed [SIDX_W-1:0] idx_s, last_s, lmax_s, boff_s, l_s;
  logic signed [SIDX_W-1:0] exp_bound, bin_bound, j_s;
  logic [LMAX_W-1:0] bin_off;
  logic              exp_in, bin_in, cand_ok;

  // object count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // leaf count saturated to the supported range
  always_comb begin
    if (count_q < CNT_W'(MIN_OBJECTS)) begin
      n_clamp = CNT_W'(MIN_OBJECTS);
    end else if (count_q > CNT_W'(MAX_OBJECTS)) begin
      n_clamp = CNT_W'(MAX_OBJECTS);
    end else begin
      n_clamp = count_q;
    end
  end
  assign last_n   = n_clamp - CNT_W'(1);
  assign node_bad = CNT_W'(in_data_i.node_index) >= last_n;

  // prefix length of the held key against the word just read
  assign rd_ext   = 32'(ram_rdata_i);
  assign code_ext = 32'(code_q);
  assign plen_rd  = lzc32(code_ext ^ rd_ext);

  // signed bound arithmetic for the range searches
  assign idx_s     = signed'(SIDX_W'(idx_q));
  assign last_s    = signed'(SIDX_W'(last_q));
  assign lmax_s    = signed'(SIDX_W'(lmax_q));
  assign bin_off   = l_q + t_q;
  assign boff_s    = signed'(SIDX_W'(bin_off));
  assign l_s       = signed'(SIDX_W'(l_q));
  assign exp_bound = neg_q ? (idx_s - lmax_s) : (idx_s + lmax_s);
  assign bin_bound = neg_q ? (idx_s - boff_s) : (idx_s + boff_s);
  assign j_s       = neg_q ? (idx_s - l_s) : (idx_s + l_s);
  assign exp_in    = !exp_bound[SIDX_W-1] && (exp_bound <= last_s);
  assign bin_in    = !bin_bound[SIDX_W-1] && (bin_bound <= last_s);

  // split step halving and candidate
  assign step_inc = {1'b0, step_q} + (CNT_W+1)'(1);
  assign step_nx  = step_inc[CNT_W:1];
  assign cand_sum = CNT_W'(split_q) + step_nx;
  assign cand_ok  = cand_sum < CNT_W'(hi_q);
  assign lohi_sum = CNT_W'(lo_q) + CNT_W'(hi_q);

  // status to the controller
  always_comb begin
    stat_o.invalid    = invalid_q;
    stat_o.root       = (idx_q == '0);
    stat_o.exp_in     = exp_in;
    stat_o.gt         = plen_rd > thr_q;
    stat_o.t_zero     = (t_q == '0);
    stat_o.bin_in     = bin_in;
    stat_o.keys_equal = (code_q == ram_rdata_i);
    stat_o.cand_ok    = cand_ok;
    stat_o.more_nx    = step_nx > CNT_W'(1);
    stat_o.more_q     = step_q > CNT_W'(1);
  end

  // key memory access
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = in_data_i.load_slot;
    ram_wdata_o = KEY_BITS'(in_data_i.key_value + 32'(in_data_i.load_slot));
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;
    case (cmd_i.op)
      OP_LOAD: begin
        ram_we_o = 1'b1;
      end
      OP_RD_SELF: begin
        ram_re_o = 1'b1;
      end
      OP_RD_UP: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_q + IDX_W'(1);
      end
      OP_RD_DOWN: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_q - IDX_W'(1);
      end
      OP_EXP_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = exp_bound[IDX_W-1:0];
      end
      OP_BIN_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = bin_bound[IDX_W-1:0];
      end
      OP_SPL_RD_LO: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = lo_q;
      end
      OP_SPL_RD_HI: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = hi_q;
      end
      OP_SPL_ADDR: begin
        ram_re_o    = cand_ok;
        ram_raddr_o = cand_sum[IDX_W-1:0];
      end
      default: begin
        ram_re_o = 1'b0;
      end
    endcase
  end

  // working registers of the node search
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        idx_q     <= in_data_i.node_index;
        last_q    <= last_n[IDX_W-1:0];
        invalid_q <= node_bad;
      end
      OP_RD_UP: begin
        code_q <= ram_rdata_i;
      end
      OP_RD_DOWN: begin
        up_q <= plen_rd;
      end
      // direction goes downward only when the upper prefix is shorter
      OP_DIR: begin
        if (up_q < plen_rd) begin
          neg_q <= 1'b1;
          thr_q <= up_q;
        end else begin
          neg_q <= 1'b0;
          thr_q <= plen_rd;
        end
        lmax_q <= LMAX_W'(2);
      end
      OP_EXP_GROW: begin
        lmax_q <= lmax_q << 1;
      end
      OP_BIN_INIT: begin
        l_q <= '0;
        t_q <= lmax_q >> 1;
      end
      OP_BIN_SKIP: begin
        t_q <= t_q >> 1;
      end
      OP_BIN_CHK: begin
        if (plen_rd > thr_q) begin
          l_q <= bin_off;
        end
        t_q <= t_q >> 1;
      end
      OP_RANGE: begin
        lo_q <= neg_q ? j_s[IDX_W-1:0] : idx_q;
        hi_q <= neg_q ? idx_q : j_s[IDX_W-1:0];
      end
      OP_ROOT: begin
        lo_q <= '0;
        hi_q <= last_q;
      end
      OP_SPL_RD_HI: begin
        code_q <= ram_rdata_i;
      end
      // equal end keys split at the midpoint
      OP_SPL_CMP: begin
        if (code_q == ram_rdata_i) begin
          split_q <= lohi_sum[CNT_W-1:1];
        end else begin
          thr_q   <= plen_rd;
          split_q <= lo_q;
          step_q  <= CNT_W'(hi_q) - CNT_W'(lo_q);
        end
      end
      OP_SPL_ADDR: begin
        step_q <= step_nx;
        cand_q <= cand_sum[IDX_W-1:0];
      end
      OP_SPL_CHK: begin
        if (plen_rd > thr_q) begin
          split_q <= cand_q;
        end
      end
      OP_EMIT: begin
        if (invalid_q) begin
          res_q.range_first   <= '0;
          res_q.range_last    <= '0;
          res_q.split_point   <= '0;
          res_q.left_is_leaf  <= 1'b0;
          res_q.right_is_leaf <= 1'b0;
          res_q.node_invalid  <= 1'b1;
        end else begin
          res_q.range_first   <= lo_q;
          res_q.range_last    <= hi_q;
          res_q.split_point   <= split_q;
          res_q.left_is_leaf  <= (split_q == lo_q);
          res_q.right_is_leaf <= ((CNT_W'(split_q) + CNT_W'(1)) == CNT_W'(hi_q));
          res_q.node_invalid  <= 1'b0;
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

// File: design/radix_tree_node_builder_top.sv
`timescale 1ns / 1ps
// Radix tree node builder over up to 1024 sorted keys held in an on-chip key
// memory. A load transaction writes key plus slot into the memory. A build
// transaction returns one internal node: its leaf range, split point and child
// kinds, or the invalid flag when the node index is not below object_count
// minus one. Every other build walks the key memory through its single read
// port, each probe an address step, then a compare on the registered data, in
// an exponential search, a range binary search and a split binary search,
// whose probe counts grow with log2 of the node's range length; node 0 skips
// the range search. One build is in flight at a time, and the next transaction
// is taken while the last result waits in the output register. The key memory
// has no reset and needs no clearing pass; keys must be loaded before a build
// reads them.
module radix_tree_node_builder_top #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rtnb_pkg::rtnb_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rtnb_pkg::rtnb_out_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rtnb_pkg::CNT_W-1:0]  cfg_data_i
);
  import rtnb_pkg::*;

  rtnb_cmd_t           cmd;
  rtnb_stat_t          stat;
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0] ram_wdata, ram_rdata;

  // the user writes configuration only while idle; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // sequencer
  rtnb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // search registers and result register
  rtnb_dp #(
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_o       (out_data_o)
  );

  // key memory
  rtnb_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_OBJECTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: design/rtnb_checker.sv
`timescale 1ns / 1ps
`include "radix_tree_node_builder_top_macros.svh"
module rtnb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rtnb_pkg::rtnb_out_t out_data_o
);

  // a stalled result transaction stays put
  `RTNB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // an invalid node carries an all-zero body
  `RTNB_ASSERT_NOW(a_invalid_zero, out_valid_o && out_data_o.node_invalid, out_data_o.range_first == '0 && out_data_o.range_last == '0 && out_data_o.split_point == '0 && !out_data_o.left_is_leaf && !out_data_o.right_is_leaf)

  // the split lies inside the node range
  `RTNB_ASSERT_NOW(a_split_in_range, out_valid_o && !out_data_o.node_invalid, out_data_o.range_first <= out_data_o.split_point && out_data_o.split_point <= out_data_o.range_last)

  // left child is a leaf exactly when the split sits on the first leaf
  `RTNB_ASSERT_NOW(a_left_leaf, out_valid_o && !out_data_o.node_invalid, out_data_o.left_is_leaf == (out_data_o.split_point == out_data_o.range_first))

endmodule

bind radix_tree_node_builder_top rtnb_checker u_rtnb_checker (.*);
